>>> rtl/fat32lc_pkg.sv
`timescale 1ns / 1ps

package fat32lc_pkg;

    // Shared adder width: covers 33-bit magnitudes plus a borrow bit.
    localparam int ALU_W = 34;

    // Field widths
    localparam int BYTES_W    = 64;
    localparam int SECT_SHIFT = 9;
    localparam int DEV_W      = BYTES_W - SECT_SHIFT;
    localparam int START_W    = 25;
    localparam int RSVD_W     = 16;
    localparam int VOL_W      = 32;
    localparam int FAT_W      = 26;   // internal FAT size, up to 2^25
    localparam int FATOUT_W   = 22;
    localparam int CLUSOUT_W  = 28;
    localparam int SPC_W      = 8;
    localparam int SHIFT_W    = 3;
    localparam int CAND_W     = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PARTITION_START = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED_COUNT  = 8'd1;

    localparam logic [START_W-1:0] START_RESET = 25'd8192;
    localparam logic [RSVD_W-1:0]  RSVD_RESET  = 16'd32;

    // Cluster size thresholds, in sectors
    localparam logic [VOL_W-1:0] SPC8_MIN  = 32'd532480;
    localparam logic [VOL_W-1:0] SPC16_MIN = 32'd16777216;
    localparam logic [VOL_W-1:0] SPC32_MIN = 32'd33554432;

    // Valid FAT32 cluster count range
    localparam logic [VOL_W-1:0] CLUS_MIN = 32'd65525;
    localparam logic [VOL_W-1:0] CLUS_MAX = 32'h0FFF_FFF5;

    // ceil((clus + 2) * 4 / 512) == (clus + 129) >> 7
    localparam logic [ALU_W-1:0] FAT_ROUND_ADD = 34'd129;
    localparam int               FAT_ENTRY_SHIFT = 7;

    localparam logic [CAND_W-1:0] LAST_CAND = 4'd8;

    // Request to the shared adder/subtractor
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

endpackage

>>> rtl/fat32lc_alu.sv
`timescale 1ns / 1ps

module fat32lc_alu
    import fat32lc_pkg::*;
(
    input  alu_req_t         req,
    output logic [ALU_W-1:0] res
);

    // a + b, or a - b in two's complement
    assign res = req.a + (req.b ^ {ALU_W{req.sub}}) + {{(ALU_W-1){1'b0}}, req.sub};

endmodule

>>> rtl/fat32_layout_calculator.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      s_device_bytes
// m_        out        m_valid / m_ready      m_layout_found, m_cluster_sectors,
//                                             m_fat_sectors, m_cluster_total,
//                                             m_volume_sectors
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction at a time on a single shared 34-bit adder/subtractor.
// A FAT round steps through overhead, remainder and next FAT size; each
// candidate that is not rejected ends with a cluster count range check.
// A transaction runs its setup (size check, then total) and up to 9 candidates.
// Reset (aresetn low, synchronous) restores register defaults; cfg always ready.
// s_ready is low while busy; a result waiting on m_ready holds the sequencer.

module fat32_layout_calculator
    import fat32lc_pkg::*;
#(
    parameter int MAX_FAT_ITERATIONS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTES_W-1:0]    s_device_bytes,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_layout_found,
    output logic [SPC_W-1:0]      m_cluster_sectors,
    output logic [FATOUT_W-1:0]   m_fat_sectors,
    output logic [CLUSOUT_W-1:0]  m_cluster_total,
    output logic [VOL_W-1:0]      m_volume_sectors,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int RND_W = $clog2(MAX_FAT_ITERATIONS + 1);
    localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(MAX_FAT_ITERATIONS - 1);

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SUM   = 4'd1;  // start + reserved, size check
    localparam logic [3:0] ST_TOTAL = 4'd2;  // capped sectors - start
    localparam logic [3:0] ST_OVH   = 4'd3;  // reserved + 2*fat
    localparam logic [3:0] ST_DIFF  = 4'd4;  // total - overhead, clusters
    localparam logic [3:0] ST_NEXT  = 4'd5;  // next FAT size estimate
    localparam logic [3:0] ST_CHK   = 4'd6;  // cluster count range check
    localparam logic [3:0] ST_OUT   = 4'd7;  // hand result to output reg

    // Configuration registers
    logic [START_W-1:0] start_reg, start_next;
    logic [RSVD_W-1:0]  rsvd_reg, rsvd_next;

    // Sequencer and datapath registers
    logic [3:0]         state_reg, state_next;
    logic [DEV_W-1:0]   dev_reg, dev_next;
    logic [VOL_W-1:0]   total_reg, total_next;
    logic [ALU_W-1:0]   ovh_reg, ovh_next;
    logic [VOL_W-1:0]   clus_reg, clus_next;
    logic [FAT_W-1:0]   fat_reg, fat_next;
    logic [RND_W-1:0]   round_reg, round_next;
    logic [CAND_W-1:0]  cand_reg, cand_next;
    logic               final_reg, final_next;
    logic               found_reg, found_next;
    logic               small_reg, small_next;

    // Output register
    logic                 m_valid_reg, m_valid_next;
    logic                 o_found_reg, o_found_next;
    logic [SPC_W-1:0]     o_spc_reg, o_spc_next;
    logic [FATOUT_W-1:0]  o_fat_reg, o_fat_next;
    logic [CLUSOUT_W-1:0] o_clus_reg, o_clus_next;
    logic [VOL_W-1:0]     o_vol_reg, o_vol_next;

    alu_req_t         alu_req;
    logic [ALU_W-1:0] alu_res;

    logic [SHIFT_W-1:0] pref_shift;
    logic [SHIFT_W-1:0] spc_shift;
    logic [VOL_W-1:0]   capped;
    logic [FAT_W-1:0]   fat_est;
    logic               rejected;
    logic               in_range;

    fat32lc_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);

    assign m_valid           = m_valid_reg;
    assign m_layout_found    = o_found_reg;
    assign m_cluster_sectors = o_spc_reg;
    assign m_fat_sectors     = o_fat_reg;
    assign m_cluster_total   = o_clus_reg;
    assign m_volume_sectors  = o_vol_reg;

    // Preferred cluster size from the partition size, as a shift
    always_comb begin
        if (total_reg >= SPC32_MIN) begin
            pref_shift = 3'd5;
        end else if (total_reg >= SPC16_MIN) begin
            pref_shift = 3'd4;
        end else if (total_reg >= SPC8_MIN) begin
            pref_shift = 3'd3;
        end else begin
            pref_shift = 3'd0;
        end
    end

    // Candidate 0 is the preferred size, then 1,2,4..128
    assign spc_shift = (cand_reg == '0) ? pref_shift : SHIFT_W'(cand_reg - 4'd1);

    assign capped = (|dev_reg[DEV_W-1:VOL_W]) ? {VOL_W{1'b1}} : dev_reg[VOL_W-1:0];

    assign fat_est  = alu_res[FAT_ENTRY_SHIFT +: FAT_W];
    // total <= overhead: negative or zero remainder
    assign rejected = alu_res[ALU_W-1] || (alu_res == '0);
    assign in_range = (clus_reg >= CLUS_MIN) && (clus_reg <= CLUS_MAX);

    // Operand select for the shared adder
    always_comb begin
        alu_req = '0;
        case (state_reg)
            ST_SUM: begin
                alu_req.a = ALU_W'(start_reg);
                alu_req.b = ALU_W'(rsvd_reg);
            end
            ST_TOTAL: begin
                alu_req.a   = ALU_W'(capped);
                alu_req.b   = ALU_W'(start_reg);
                alu_req.sub = 1'b1;
            end
            ST_OVH: begin
                alu_req.a = ALU_W'(rsvd_reg);
                alu_req.b = ALU_W'({fat_reg, 1'b0});
            end
            ST_DIFF: begin
                alu_req.a   = ALU_W'(total_reg);
                alu_req.b   = ovh_reg;
                alu_req.sub = 1'b1;
            end
            ST_NEXT: begin
                alu_req.a = ALU_W'(clus_reg);
                alu_req.b = FAT_ROUND_ADD;
            end
            default: begin
                alu_req = '0;
            end
        endcase
    end

    always_comb begin
        start_next   = start_reg;
        rsvd_next    = rsvd_reg;
        state_next   = state_reg;
        dev_next     = dev_reg;
        total_next   = total_reg;
        ovh_next     = ovh_reg;
        clus_next    = clus_reg;
        fat_next     = fat_reg;
        round_next   = round_reg;
        cand_next    = cand_reg;
        final_next   = final_reg;
        found_next   = found_reg;
        small_next   = small_reg;
        m_valid_next = m_valid_reg;
        o_found_next = o_found_reg;
        o_spc_next   = o_spc_reg;
        o_fat_next   = o_fat_reg;
        o_clus_next  = o_clus_reg;
        o_vol_next   = o_vol_reg;

        if (cfg_valid) begin
            if (cfg_index == REG_PARTITION_START) begin
                start_next = cfg_data[START_W-1:0];
            end else if (cfg_index == REG_RESERVED_COUNT) begin
                rsvd_next = cfg_data[RSVD_W-1:0];
            end
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    dev_next   = s_device_bytes[BYTES_W-1:SECT_SHIFT];
                    found_next = 1'b0;
                    small_next = 1'b0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (dev_reg <= DEV_W'(alu_res)) begin
                    small_next = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_TOTAL;
                end
            end
            ST_TOTAL: begin
                total_next = alu_res[VOL_W-1:0];
                cand_next  = '0;
                fat_next   = FAT_W'(1);
                round_next = '0;
                final_next = 1'b0;
                state_next = ST_OVH;
            end
            ST_OVH: begin
                ovh_next   = alu_res;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                if (rejected) begin
                    // candidate fails; move on
                    if (cand_reg == LAST_CAND) begin
                        state_next = ST_OUT;
                    end else begin
                        cand_next  = cand_reg + 4'd1;
                        fat_next   = FAT_W'(1);
                        round_next = '0;
                        final_next = 1'b0;
                        state_next = ST_OVH;
                    end
                end else begin
                    clus_next  = alu_res[VOL_W-1:0] >> spc_shift;
                    state_next = final_reg ? ST_CHK : ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (fat_est == fat_reg) begin
                    // converged: clus_reg already matches this FAT size
                    state_next = ST_CHK;
                end else begin
                    fat_next = fat_est;
                    if (round_reg == LAST_ROUND) begin
                        final_next = 1'b1;
                    end else begin
                        round_next = round_reg + RND_W'(1);
                    end
                    state_next = ST_OVH;
                end
            end
            ST_CHK: begin
                if (in_range) begin
                    found_next = 1'b1;
                    state_next = ST_OUT;
                end else if (cand_reg == LAST_CAND) begin
                    state_next = ST_OUT;
                end else begin
                    cand_next  = cand_reg + 4'd1;
                    fat_next   = FAT_W'(1);
                    round_next = '0;
                    final_next = 1'b0;
                    state_next = ST_OVH;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    o_found_next = found_reg;
                    o_spc_next   = found_reg ? (SPC_W'(1) << spc_shift) : '0;
                    o_fat_next   = found_reg ? fat_reg[FATOUT_W-1:0] : '0;
                    o_clus_next  = found_reg ? clus_reg[CLUSOUT_W-1:0] : '0;
                    o_vol_next   = small_reg ? '0 : total_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg   <= START_RESET;
            rsvd_reg    <= RSVD_RESET;
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            round_reg   <= '0;
            cand_reg    <= '0;
            final_reg   <= 1'b0;
            found_reg   <= 1'b0;
            small_reg   <= 1'b0;
        end else begin
            start_reg   <= start_next;
            rsvd_reg    <= rsvd_next;
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            round_reg   <= round_next;
            cand_reg    <= cand_next;
            final_reg   <= final_next;
            found_reg   <= found_next;
            small_reg   <= small_next;
        end
    end

    always_ff @(posedge aclk) begin
        dev_reg     <= dev_next;
        total_reg   <= total_next;
        ovh_reg     <= ovh_next;
        clus_reg    <= clus_next;
        fat_reg     <= fat_next;
        o_found_reg <= o_found_next;
        o_spc_reg   <= o_spc_next;
        o_fat_reg   <= o_fat_next;
        o_clus_reg  <= o_clus_next;
        o_vol_reg   <= o_vol_next;
    end

endmodule

>>> tb/tb_fat32_layout_calculator.sv
`timescale 1ns / 1ps

module tb_fat32_layout_calculator
    import fat32lc_pkg::*;
();

    // Predictor constants, kept local so the check does not lean on the RTL
    localparam int          FAT_ROUNDS    = 16;
    localparam int          CANDIDATES    = 9;
    localparam logic [31:0] SPC8_FLOOR    = 32'd532480;
    localparam logic [31:0] SPC16_FLOOR   = 32'd16777216;
    localparam logic [31:0] SPC32_FLOOR   = 32'd33554432;
    localparam logic [31:0] FAT32_MIN_CL  = 32'd65525;
    localparam logic [31:0] FAT32_MAX_CL  = 32'h0FFF_FFF5;
    localparam logic [63:0] SECTOR_CAP    = 64'hFFFF_FFFF;
    localparam int          HOLD_CYCLES   = 400;   // long m_ready hold-off
    localparam int          TAIL_CYCLES   = 500;   // > one worst-case transaction
    localparam int          MAX_REPORTS   = 10;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hFF;

    // One result transaction
    typedef struct packed {
        logic                 found;
        logic [SPC_W-1:0]     spc;
        logic [FATOUT_W-1:0]  fat;
        logic [CLUSOUT_W-1:0] clusters;
        logic [VOL_W-1:0]     volume;
    } layout_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [BYTES_W-1:0]    s_device_bytes = '0;

    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic                  m_layout_found;
    logic [SPC_W-1:0]      m_cluster_sectors;
    logic [FATOUT_W-1:0]   m_fat_sectors;
    logic [CLUSOUT_W-1:0]  m_cluster_total;
    logic [VOL_W-1:0]      m_volume_sectors;

    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    // Shadow copy of the two configuration registers
    logic [START_W-1:0] part_start = START_RESET;
    logic [RSVD_W-1:0]  rsvd_count = RSVD_RESET;

    layout_t layout_queue[$];     // predicted layouts, oldest first
    int      error_count = 0;
    bit      burst_mode  = 1'b0;  // both sides run without idle cycles
    bit      hold_req    = 1'b0;  // ask the result side for a long hold-off

    fat32_layout_calculator #(
        .MAX_FAT_ITERATIONS(FAT_ROUNDS)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_device_bytes    (s_device_bytes),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_layout_found    (m_layout_found),
        .m_cluster_sectors (m_cluster_sectors),
        .m_fat_sectors     (m_fat_sectors),
        .m_cluster_total   (m_cluster_total),
        .m_volume_sectors  (m_volume_sectors),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Safety net: the slowest legal run is under a fifth of this
    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Fixed-point search for the sectors of one FAT copy; 0 means the
    // overhead swallowed the whole volume.
    function automatic logic [31:0] fat_for_cluster_size(input logic [31:0] total,
                                                         input logic [31:0] spc);
        logic [31:0] cur;
        logic [31:0] clus;
        logic [31:0] clus_p2;
        logic [31:0] next_fat;
        logic [63:0] ovh;
        logic [63:0] entry_bytes;
        cur = 32'd1;
        for (int r = 0; r < FAT_ROUNDS; r++) begin
            ovh = {48'b0, rsvd_count} + {32'b0, cur} * 64'd2;
            if (ovh >= {32'b0, total})
                return 32'd0;
            clus        = 32'(({32'b0, total} - ovh) / {32'b0, spc});
            clus_p2     = clus + 32'd2;              // wraps at 32 bits
            entry_bytes = {32'b0, clus_p2} * 64'd4 + 64'd511;
            next_fat    = 32'(entry_bytes >> 9);
            if (next_fat == cur)
                return cur;
            cur = next_fat;
        end
        return cur;
    endfunction

    function automatic layout_t predict_layout(input logic [BYTES_W-1:0] bytes);
        logic [63:0] dev;
        logic [63:0] capped;
        logic [63:0] ovh;
        logic [63:0] vol64;
        logic [31:0] total;
        logic [31:0] pref;
        logic [31:0] spc;
        logic [31:0] fat;
        logic [31:0] clus;
        layout_t     res;
        res = '0;
        dev = bytes >> 9;
        // Device too small: all-zero result, volume included
        if (dev <= {39'b0, part_start} + {48'b0, rsvd_count})
            return res;
        capped = (dev < SECTOR_CAP) ? dev : SECTOR_CAP;
        vol64  = capped - {39'b0, part_start};
        total  = vol64[31:0];
        res.volume = total;

        pref = 32'd1;
        if (total >= SPC8_FLOOR)  pref = 32'd8;
        if (total >= SPC16_FLOOR) pref = 32'd16;
        if (total >= SPC32_FLOOR) pref = 32'd32;

        // Preferred size first, then 1..128
        for (int i = 0; i < CANDIDATES; i++) begin
            spc = (i == 0) ? pref : (32'd1 << (i - 1));
            fat = fat_for_cluster_size(total, spc);
            ovh = {48'b0, rsvd_count} + {32'b0, fat} * 64'd2;
            if (fat != 32'd0 && ovh < {32'b0, total}) begin
                clus = 32'(({32'b0, total} - ovh) / {32'b0, spc});
                if (clus >= FAT32_MIN_CL && clus <= FAT32_MAX_CL) begin
                    res.found    = 1'b1;
                    res.spc      = spc[SPC_W-1:0];
                    res.fat      = fat[FATOUT_W-1:0];
                    res.clusters = clus[CLUSOUT_W-1:0];
                    return res;
                end
            end
        end
        // No candidate fits: only the volume size is reported
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Everything changes on the falling edge; handshakes are
    // sampled right after the rising edge, before the DUT's updates land.
    // ------------------------------------------------------------------

    // Send one device size. Entered and left just after a falling edge;
    // with a zero gap s_valid stays high straight into the next transaction.
    task automatic send_device(input logic [BYTES_W-1:0] bytes);
        int      gap;
        layout_t predicted;
        gap       = burst_mode ? 0 : $urandom_range(0, 15);
        predicted = predict_layout(bytes);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_device_bytes <= bytes;
        do @(posedge aclk); while (!s_ready);
        layout_queue.push_back(predicted);
        @(negedge aclk);
    endtask

    // Register write; only issued while no transaction is in flight
    task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_PARTITION_START)
            part_start = data[START_W-1:0];
        else if (idx == REG_RESERVED_COUNT)
            rsvd_count = data[RSVD_W-1:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Stop offering and wait until every predicted layout has come back
    task automatic wait_layouts_drained();
        s_valid <= 1'b0;
        while (layout_queue.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [63:0] rand_device_bytes();
        logic [63:0] base;
        logic [63:0] sectors;
        logic [63:0] raw;
        logic [63:0] th;
        base    = {39'b0, part_start} + {48'b0, rsvd_count};
        raw     = {$urandom, $urandom};
        sectors = '0;
        case ($urandom_range(0, 9))
            0: begin
                // straddle the too-small boundary
                sectors = base + 64'($urandom_range(0, 4));
                sectors = (sectors >= 64'd2) ? sectors - 64'd2 : 64'd0;
            end
            1: sectors = 64'($urandom_range(0, 300000));
            // around the smallest volume that still holds 65525 clusters
            2: sectors = base + 64'd65951 + 64'($urandom_range(0, 1200));
            3: begin
                case ($urandom_range(0, 2))
                    0:       th = {32'b0, SPC8_FLOOR};
                    1:       th = {32'b0, SPC16_FLOOR};
                    default: th = {32'b0, SPC32_FLOOR};
                endcase
                sectors = {39'b0, part_start} + th - 64'd4
                          + 64'($urandom_range(0, 8));
            end
            4, 5, 6: sectors = {39'b0, part_start}
                               + ({32'b0, $urandom} >> $urandom_range(0, 24));
            7: sectors = 64'hFFFF_FFFD + 64'($urandom_range(0, 4));   // sector cap
            8: return raw;
            default: return raw >> $urandom_range(0, 63);
        endcase
        return (sectors << 9) | 64'($urandom_range(0, 511));
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall per transaction, plus one long hold-off
    // on request, counted here so the input side keeps pushing meanwhile.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            stall = burst_mode ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    // Scoreboard: every accepted result against the oldest prediction
    always @(posedge aclk) begin : layout_check
        layout_t exp_l;
        layout_t got_l;
        if (aresetn && m_valid && m_ready) begin
            got_l = '{m_layout_found, m_cluster_sectors, m_fat_sectors,
                      m_cluster_total, m_volume_sectors};
            if (layout_queue.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result found=%0d spc=%0d fat=%0d cl=%0d vol=%0d",
                             $realtime, got_l.found, got_l.spc, got_l.fat,
                             got_l.clusters, got_l.volume);
            end else begin
                exp_l = layout_queue.pop_front();
                if (got_l.found !== exp_l.found || got_l.spc !== exp_l.spc ||
                    got_l.fat !== exp_l.fat || got_l.clusters !== exp_l.clusters ||
                    got_l.volume !== exp_l.volume) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t: mismatch (start=%0d rsvd=%0d)",
                                 $realtime, part_start, rsvd_count);
                        $display("  exp found=%0d spc=%0d fat=%0d cl=%0d vol=%0d",
                                 exp_l.found, exp_l.spc, exp_l.fat,
                                 exp_l.clusters, exp_l.volume);
                        $display("  got found=%0d spc=%0d fat=%0d cl=%0d vol=%0d",
                                 got_l.found, got_l.spc, got_l.fat,
                                 got_l.clusters, got_l.volume);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: zero and full-scale sizes, the too-small edge, an
    // unusable sliver, the cluster-size thresholds and the 32-bit cap.
    task automatic test_reset_defaults();
        logic [63:0] sect_list[13];
        sect_list = '{64'd0, 64'd8224, 64'd8225, 64'd8192 + 64'd66000,
                      64'd8192 + 64'd66600, 64'd8192 + 64'd532479,
                      64'd8192 + 64'd532480, 64'd8192 + 64'd16777215,
                      64'd8192 + 64'd16777216, 64'd8192 + 64'd33554432,
                      64'hFFFF_FFFE, 64'hFFFF_FFFF, 64'h1_0000_0000};
        foreach (sect_list[i])
            send_device((sect_list[i] << 9) | ((i % 2) ? 64'd511 : 64'd0));
        send_device(64'hFFFF_FFFF_FFFF_FFFF);
        wait_layouts_drained();
    endtask

    // Register extremes, zero reserved, masking of wide data, unmapped index
    task automatic test_register_extremes();
        write_register(REG_PARTITION_START, 32'd0);
        write_register(REG_RESERVED_COUNT, 32'd1);
        send_device(64'd1 << 9);            // too small
        send_device(64'd2 << 9);            // two sectors, nothing fits
        send_device(64'hFFFF_FFFF_FFFF_FFFF);
        wait_layouts_drained();

        write_register(REG_PARTITION_START, 32'd16777216);
        write_register(REG_RESERVED_COUNT, 32'd65535);
        send_device((64'd16777216 + 64'd65535) << 9);
        send_device((64'd16777216 + 64'd65535 + 64'd70000) << 9);
        send_device(64'hFFFF_FFFF_FFFF_FFFF);
        wait_layouts_drained();

        // all-ones start keeps only 25 bits; upper half clears reserved to 0
        write_register(REG_PARTITION_START, 32'hFFFF_FFFF);
        write_register(REG_RESERVED_COUNT, 32'hFFFF_0000);
        write_register(REG_UNMAPPED, $urandom);
        send_device((64'h1FF_FFFF + 64'd1) << 9);
        send_device((64'h1FF_FFFF + 64'd70000) << 9);
        send_device(64'hFFFF_FFFF_FFFF_FFFF);
        wait_layouts_drained();
    endtask

    // Long result hold-off while the input keeps offering back to back
    task automatic test_output_backpressure();
        write_register(REG_PARTITION_START, 32'd8192);
        write_register(REG_RESERVED_COUNT, 32'd32);
        hold_req   = 1'b1;
        burst_mode = 1'b1;
        repeat (12) send_device(rand_device_bytes());
        burst_mode = 1'b0;
        wait_layouts_drained();
    endtask

    // Random sizes over several register settings, some stretches unthrottled
    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] start_val;
        logic [CFG_DATA_W-1:0] rsvd_val;
        for (int phase = 0; phase < 6; phase++) begin
            case ($urandom_range(0, 3))
                0:       start_val = 32'd0;
                1:       start_val = 32'd8192;
                2:       start_val = 32'd2048;
                default: start_val = $urandom_range(0, 16777216);
            endcase
            case ($urandom_range(0, 4))
                0:       rsvd_val = 32'd1;
                1:       rsvd_val = 32'd32;
                2:       rsvd_val = $urandom_range(1, 64);
                3:       rsvd_val = $urandom_range(1, 65535);
                default: rsvd_val = 32'd0;
            endcase
            write_register(REG_PARTITION_START, start_val);
            write_register(REG_RESERVED_COUNT, rsvd_val);
            for (int seg = 0; seg < 4; seg++) begin
                burst_mode = ($urandom_range(0, 3) == 0);
                repeat (26) send_device(rand_device_bytes());
            end
            burst_mode = 1'b0;
            wait_layouts_drained();
        end
    endtask

    initial begin : main_seq
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic();

        wait_layouts_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (error_count == 0 && layout_queue.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/fat32lc_pkg.sv
rtl/fat32lc_alu.sv
rtl/fat32_layout_calculator.sv
tb/tb_fat32_layout_calculator.sv
